// File: rtl/lfhs_pkg.sv
// ----------------------------------------------------------------------------
// lfhs_pkg: shared types and constants of the fire heat simulation
// Transaction payloads, per-cell command, reset values and small helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package lfhs_pkg;

	localparam int CELLS_DEF       = 10;
	localparam int SPARK_CELLS_DEF = 7;
	localparam int DRAW_CELLS      = 10;
	localparam int DRAWS_PER_WORD  = 5;

	localparam int HEAT_W    = 8;
	localparam int DRAW_W    = 8;
	localparam int STEP_W    = $clog2(DRAW_W);
	localparam int PIX_W     = 4;
	localparam int BOUND_W   = 10;
	localparam int SUM_W     = 10;
	localparam int DIV3_W    = 19;
	localparam int DIV3_SH   = 11;
	localparam int DIV3_MUL  = 683;
	localparam int RECIP_SH  = 20;
	localparam int COOL_PROD_W = 30;
	localparam int PICK_SH     = 16;
	localparam int PICK_MUL_W  = 17;
	localparam int PICK_PROD_W = 25;

	localparam logic [7:0] COOLING_RST = 8'd50;
	localparam logic [7:0] SPARK_RST   = 8'd50;
	localparam logic [7:0] SPARK_BASE  = 8'd160;
	localparam logic [7:0] SPARK_SPAN  = 8'd95;
	localparam logic [7:0] ROLL_WRAP   = 8'd255;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_COOLING = 1'b0;
	localparam logic REG_SPARK   = 1'b1;

	typedef struct packed {
		logic [39:0] cool_draws_low;
		logic [39:0] cool_draws_high;
		logic [7:0]  spark_roll;
		logic [7:0]  spark_cell_draw;
		logic [7:0]  spark_heat_draw;
	} in_item_t;

	typedef struct packed {
		logic [3:0] pixel_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_pixel;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic cool_step;
		logic cool_apply;
		logic diffuse;
		logic spark;
		logic rotate;
	} cell_ctrl_t;

	// Byte modulo 95, at most two subtractions.
	function automatic logic [7:0] mod95(input logic [7:0] x);
		logic [7:0] r;
		if (x >= 8'(2 * SPARK_SPAN)) begin
			r = x - 8'(2 * SPARK_SPAN);
		end else if (x >= SPARK_SPAN) begin
			r = x - SPARK_SPAN;
		end else begin
			r = x;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/lfhs_cell.sv
// ----------------------------------------------------------------------------
// lfhs_cell: one heat cell of the fire row
// Holds a cell's heat, works out its cooldown bit-serially, and takes part
// in diffusion, spark ignition and the output rotation with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module lfhs_cell (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  lfhs_pkg::cell_ctrl_t                ctrl,
	input  wire  [lfhs_pkg::DRAW_W-1:0]         draw,
	input  wire  [lfhs_pkg::BOUND_W-1:0]        bound,
	input  wire  [lfhs_pkg::HEAT_W-1:0]         nbr1_heat,
	input  wire  [lfhs_pkg::HEAT_W-1:0]         nbr2_heat,
	input  wire  [lfhs_pkg::HEAT_W-1:0]         next_heat,
	input  wire  [lfhs_pkg::HEAT_W-1:0]         spark_add,
	output logic [lfhs_pkg::HEAT_W-1:0]         heat
);

	logic [lfhs_pkg::HEAT_W-1:0]  heat_q;
	logic [lfhs_pkg::DRAW_W-1:0]  draw_q;
	logic [lfhs_pkg::DRAW_W-1:0]  rem_q;
	logic [lfhs_pkg::DRAW_W:0]    cand;
	logic                         cand_ge;
	logic [lfhs_pkg::SUM_W-1:0]   diff_sum;
	logic [lfhs_pkg::DIV3_W-1:0]  diff_prod;
	logic [lfhs_pkg::HEAT_W-1:0]  cooled;

	assign cand    = {rem_q, draw_q[lfhs_pkg::DRAW_W-1]};
	assign cand_ge = {1'b0, cand} >= bound;

	// (a + 2b) / 3 through a reciprocal multiply, exact for sums up to 765
	assign diff_sum  = {2'b00, nbr1_heat} + {1'b0, nbr2_heat, 1'b0};
	assign diff_prod = {9'd0, diff_sum} * lfhs_pkg::DIV3_W'(lfhs_pkg::DIV3_MUL);

	assign cooled = (rem_q > heat_q) ? '0 : heat_q - rem_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			draw_q <= draw;
			rem_q  <= '0;
		end else if (ctrl.cool_step) begin
			draw_q <= {draw_q[lfhs_pkg::DRAW_W-2:0], 1'b0};
			rem_q  <= cand_ge ? lfhs_pkg::DRAW_W'({1'b0, cand} - bound) :
				cand[lfhs_pkg::DRAW_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heat_q <= '0;
		end else if (ctrl.cool_apply) begin
			heat_q <= cooled;
		end else if (ctrl.diffuse) begin
			heat_q <= diff_prod[lfhs_pkg::DIV3_SH +: lfhs_pkg::HEAT_W];
		end else if (ctrl.spark) begin
			heat_q <= heat_q + spark_add;
		end else if (ctrl.rotate) begin
			heat_q <= next_heat;
		end
	end

	assign heat = heat_q;

endmodule

`default_nettype wire

// File: rtl/lfhs_pixel_out.sv
// ----------------------------------------------------------------------------
// lfhs_pixel_out: heat to colour mapping and output register
// Maps one heat value to RGB and holds the result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lfhs_pixel_out (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              load,
	input  wire  [lfhs_pkg::HEAT_W-1:0]      heat,
	input  wire  [lfhs_pkg::PIX_W-1:0]       index,
	input  wire                              last,
	output logic                             free,
	output logic                             out_valid,
	input  wire                              out_ready,
	output lfhs_pkg::out_item_t              out_data
);

	logic [15:0]             scaled;
	logic [16:0]             quot;
	logic [7:0]              t;
	logic [7:0]              ramp;
	lfhs_pkg::out_item_t     pix;
	lfhs_pkg::out_item_t     data_q;
	logic                    valid_q;

	// t = (h*191 + 127) / 255; divide by 255 as (x + (x >> 8) + 1) >> 8
	assign scaled = ({8'd0, heat} * 16'd191) + 16'd127;
	assign quot   = {1'b0, scaled} + {9'd0, scaled[15:8]} + 17'd1;
	assign t      = quot[15:8];
	assign ramp   = {t[5:0], 2'b00};

	always_comb begin
		pix.pixel_index = index;
		pix.last_pixel  = last;
		if (t > 8'h80) begin
			pix.red   = 8'hFF;
			pix.green = 8'hFF;
			pix.blue  = ramp;
		end else if (t > 8'h40) begin
			pix.red   = 8'hFF;
			pix.green = ramp;
			pix.blue  = 8'h00;
		end else begin
			pix.red   = ramp;
			pix.green = 8'h00;
			pix.blue  = 8'h00;
		end
	end

	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= pix;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

`default_nettype wire

// File: rtl/led_fire_heat_simulation_top.sv
// ----------------------------------------------------------------------------
// led_fire_heat_simulation_top: fire heat simulation with colour output
// Row of heat cells stepped once per input transaction, colours streamed out.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction carries the random bytes for one animation tick.
//   The block cools every cell, diffuses heat upward, may ignite a spark,
//   then sends one output transaction per cell (index 0 first) with the RGB
//   colour; last_pixel marks the final cell of the tick.
//   Sequence: the cooldown remainders are formed one bit per cycle in every
//   cell, then the apply, diffusion and spark states follow in turn; the
//   colours are then registered one per cycle while the receiver does not
//   stall, one per working cell (at most 10). in_ready is high only between
//   ticks.
//   A receiver stall holds the current colour in the output register and
//   stops the cell rotation until it is taken; nothing is dropped.
//   Reset clears all cell heats and loads cooling and spark_chance with 50.
//   The APB port (cooling at 0x0, spark_chance at 0x4) must be written only
//   while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module led_fire_heat_simulation_top #(
	parameter int CELLS       = lfhs_pkg::CELLS_DEF,
	parameter int SPARK_CELLS = lfhs_pkg::SPARK_CELLS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  lfhs_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  wire                               out_ready,
	output lfhs_pkg::out_item_t               out_data,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [lfhs_pkg::APB_AW-1:0]       paddr,
	input  wire  [lfhs_pkg::APB_DW-1:0]       pwdata,
	output logic [lfhs_pkg::APB_DW-1:0]       prdata,
	output logic                              pready
);

	localparam int WORK = (CELLS > lfhs_pkg::DRAW_CELLS) ? lfhs_pkg::DRAW_CELLS : CELLS;
	localparam int RECIP = ((1 << lfhs_pkg::RECIP_SH) + CELLS - 1) / CELLS;
	localparam logic [lfhs_pkg::COOL_PROD_W-1:0] COOL_MUL =
		lfhs_pkg::COOL_PROD_W'(10 * RECIP);
	localparam logic [lfhs_pkg::BOUND_W-1:0] BOUND_RST =
		lfhs_pkg::BOUND_W'(500 / CELLS + 2);
	localparam logic [lfhs_pkg::PIX_W-1:0] PIX_LAST = lfhs_pkg::PIX_W'(WORK - 1);
	localparam logic [lfhs_pkg::STEP_W-1:0] STEP_LAST =
		lfhs_pkg::STEP_W'(lfhs_pkg::DRAW_W - 1);
	localparam logic [lfhs_pkg::PICK_MUL_W-1:0] PICK_MUL =
		lfhs_pkg::PICK_MUL_W'(((1 << lfhs_pkg::PICK_SH) + SPARK_CELLS - 1) / SPARK_CELLS);
	localparam logic [7:0] PICK_DIV = 8'(SPARK_CELLS);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_COOL  = 6'b000010,
		S_APPLY = 6'b000100,
		S_DIFF  = 6'b001000,
		S_SPARK = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t                              state_q;
	logic [lfhs_pkg::STEP_W-1:0]         step_q;
	logic [lfhs_pkg::PIX_W-1:0]          pix_q;
	logic [7:0]                          cooling_q;
	logic [7:0]                          spark_chance_q;
	logic [lfhs_pkg::BOUND_W-1:0]        bound_q;
	logic                                spark_hit_q;
	logic [3:0]                          spark_cell_q;
	logic [lfhs_pkg::HEAT_W-1:0]         spark_add_q;

	logic                                in_acc;
	logic                                wr_en;
	logic [lfhs_pkg::COOL_PROD_W-1:0]    cool_prod;
	logic [7:0]                          roll_mod;
	logic [lfhs_pkg::PICK_PROD_W-1:0]    pick_prod;
	logic [7:0]                          pick_quot;
	logic [7:0]                          pick_rem;
	logic                                out_free;
	logic                                emit;
	lfhs_pkg::cell_ctrl_t                base_ctrl;
	logic [lfhs_pkg::HEAT_W-1:0]         heat_w [WORK];

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign emit     = (state_q == S_EMIT) && out_free;

	// Configuration port
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cool_prod = {22'd0, pwdata[7:0]} * COOL_MUL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooling_q      <= lfhs_pkg::COOLING_RST;
			spark_chance_q <= lfhs_pkg::SPARK_RST;
			bound_q        <= BOUND_RST;
		end else if (wr_en) begin
			case (paddr[2])
				lfhs_pkg::REG_COOLING: begin
					cooling_q <= pwdata[7:0];
					bound_q   <= cool_prod[lfhs_pkg::RECIP_SH +: lfhs_pkg::BOUND_W] +
						lfhs_pkg::BOUND_W'(2);
				end
				lfhs_pkg::REG_SPARK: begin
					spark_chance_q <= pwdata[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			lfhs_pkg::REG_COOLING: prdata = {24'd0, cooling_q};
			lfhs_pkg::REG_SPARK:   prdata = {24'd0, spark_chance_q};
			default:               prdata = '0;
		endcase
	end

	// Spark decision, latched with the transaction
	assign roll_mod = (in_data.spark_roll == lfhs_pkg::ROLL_WRAP) ? 8'd0 : in_data.spark_roll;

	// Cell pick: draw mod SPARK_CELLS through a reciprocal multiply
	assign pick_prod = {17'd0, in_data.spark_cell_draw} * {8'd0, PICK_MUL};
	assign pick_quot = pick_prod[lfhs_pkg::PICK_SH +: 8];
	assign pick_rem  = in_data.spark_cell_draw - pick_quot * PICK_DIV;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			spark_hit_q  <= roll_mod < spark_chance_q;
			spark_cell_q <= pick_rem[3:0];
			spark_add_q  <= lfhs_pkg::SPARK_BASE + lfhs_pkg::mod95(in_data.spark_heat_draw);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			pix_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					step_q <= '0;
					if (in_acc) begin
						state_q <= S_COOL;
					end
				end
				S_COOL: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: state_q <= S_DIFF;
				S_DIFF:  state_q <= S_SPARK;
				S_SPARK: begin
					pix_q   <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						pix_q <= pix_q + 1'b1;
						if (pix_q == PIX_LAST) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign base_ctrl.load       = in_acc;
	assign base_ctrl.cool_step  = (state_q == S_COOL);
	assign base_ctrl.cool_apply = (state_q == S_APPLY);
	assign base_ctrl.diffuse    = (state_q == S_DIFF);
	assign base_ctrl.spark      = (state_q == S_SPARK) && spark_hit_q;
	assign base_ctrl.rotate     = emit;

	// Cell row; during output the heats rotate toward cell 0 and come back whole
	for (genvar k = 0; k < WORK; k++) begin : g_cell
		lfhs_pkg::cell_ctrl_t          ctrl;
		logic [lfhs_pkg::DRAW_W-1:0]   draw;
		logic [lfhs_pkg::HEAT_W-1:0]   nbr1;
		logic [lfhs_pkg::HEAT_W-1:0]   nbr2;

		always_comb begin
			ctrl = base_ctrl;
			ctrl.diffuse = base_ctrl.diffuse && (k >= 2);
			ctrl.spark   = base_ctrl.spark && (spark_cell_q == 4'(k));
		end

		if (k < lfhs_pkg::DRAWS_PER_WORD) begin : g_lo
			assign draw = in_data.cool_draws_low[k*8 +: 8];
		end else begin : g_hi
			assign draw = in_data.cool_draws_high[(k - lfhs_pkg::DRAWS_PER_WORD)*8 +: 8];
		end

		if (k >= 2) begin : g_nbr
			assign nbr1 = heat_w[k-1];
			assign nbr2 = heat_w[k-2];
		end else begin : g_edge
			assign nbr1 = '0;
			assign nbr2 = '0;
		end

		lfhs_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.draw      (draw),
			.bound     (bound_q),
			.nbr1_heat (nbr1),
			.nbr2_heat (nbr2),
			.next_heat (heat_w[(k + 1) % WORK]),
			.spark_add (spark_add_q),
			.heat      (heat_w[k])
		);
	end

	lfhs_pixel_out u_pixel_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (emit),
		.heat      (heat_w[0]),
		.index     (pix_q),
		.last      (pix_q == PIX_LAST),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
